[design/amvi_pkg.sv]
// shared widths and constants for the accelerometer mean / velocity integrator
// no dependencies

package amvi_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int SAMPLE_BITS = 16;

  localparam int RAW_W    = 16;
  localparam int GAIN_W   = 17;
  localparam int ACC_W    = 25;
  localparam int SUM_W    = 40;
  localparam int VSUM_W   = 64;
  localparam int MVEL_W   = 49;
  localparam int TOTAL_W  = 24;
  localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;
  localparam int SHIFT    = 8;
  localparam int DIV_CNT_W = $clog2(VSUM_W);

  localparam logic [GAIN_W-1:0]     GAIN_RESET = GAIN_W'(10045);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

endpackage

[design/amvi_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// unsigned 64-bit dividend by a count-wide divisor; uses amvi_pkg

module amvi_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [amvi_pkg::VSUM_W-1:0]         dividend,
  input  logic [amvi_pkg::COUNT_BITS-1:0]     divisor,
  output logic                                done,
  output logic [amvi_pkg::VSUM_W-1:0]         quotient
);

  logic                                  run_r;
  logic                                  done_r;
  logic [amvi_pkg::DIV_CNT_W-1:0]        cnt_r;
  logic [amvi_pkg::COUNT_BITS-1:0]       rem_r;
  logic [amvi_pkg::VSUM_W-1:0]           dvd_r;
  logic [amvi_pkg::COUNT_BITS:0]         rem_sh;
  logic                                  ge;
  logic [amvi_pkg::COUNT_BITS:0]         rem_diff;
  logic [amvi_pkg::COUNT_BITS-1:0]       rem_nxt;
  logic [amvi_pkg::VSUM_W-1:0]           dvd_nxt;

  assign rem_sh   = {rem_r, dvd_r[amvi_pkg::VSUM_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign rem_nxt  = ge ? rem_diff[amvi_pkg::COUNT_BITS-1:0]
                       : rem_sh[amvi_pkg::COUNT_BITS-1:0];
  assign dvd_nxt  = {dvd_r[amvi_pkg::VSUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {amvi_pkg::DIV_CNT_W{1'b1}}) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

[design/accel_mean_velocity_integrator_core.sv]
// top level: scales three-axis samples, keeps saturating sums and velocities,
// reports means through a shared bit-serial divider; uses amvi_pkg and amvi_div

// A sample item keeps busy high through a multiply, an accumulate and a
// velocity-sum step for each axis in turn, then one finish step, and skips
// the velocity-sum steps when the count is full; its result strobes on
// out_valid in the first cycle with busy low. A report item runs six
// divisions in turn through one radix-2 divider with busy high throughout; a
// report with no samples goes straight to the finish step. The result is
// shown for exactly one cycle and cannot be stalled. A new item may start in
// the cycle its predecessor's result is shown. No clearing pass after reset.

module accel_mean_velocity_integrator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [amvi_pkg::GAIN_W-1:0]           cfg_wr_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic signed [amvi_pkg::RAW_W-1:0]     in_raw_x,
  input  logic signed [amvi_pkg::RAW_W-1:0]     in_raw_y,
  input  logic signed [amvi_pkg::RAW_W-1:0]     in_raw_z,
  output logic                                  out_valid,
  output logic                                  out_result_kind,
  output logic signed [amvi_pkg::ACC_W-1:0]     out_accel_x_out,
  output logic signed [amvi_pkg::ACC_W-1:0]     out_accel_y_out,
  output logic signed [amvi_pkg::ACC_W-1:0]     out_accel_z_out,
  output logic signed [amvi_pkg::MVEL_W-1:0]    out_mean_vel_x,
  output logic signed [amvi_pkg::MVEL_W-1:0]    out_mean_vel_y,
  output logic signed [amvi_pkg::MVEL_W-1:0]    out_mean_vel_z,
  output logic [amvi_pkg::TOTAL_W-1:0]          out_sample_total,
  output logic                                  out_no_samples,
  output logic                                  out_count_full
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_VSUM  = 3'd3;
  localparam logic [2:0] ST_DLOAD = 3'd4;
  localparam logic [2:0] ST_DWAIT = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  function automatic logic signed [amvi_pkg::SUM_W-1:0] sat_add_sum(
    input logic signed [amvi_pkg::SUM_W-1:0] a,
    input logic signed [amvi_pkg::ACC_W-1:0] b
  );
    logic signed [amvi_pkg::SUM_W:0] s;
    s = (amvi_pkg::SUM_W+1)'(a) + (amvi_pkg::SUM_W+1)'(b);
    if (s[amvi_pkg::SUM_W] != s[amvi_pkg::SUM_W-1]) begin
      sat_add_sum = s[amvi_pkg::SUM_W] ? {1'b1, {(amvi_pkg::SUM_W-1){1'b0}}}
                                       : {1'b0, {(amvi_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat_add_sum = s[amvi_pkg::SUM_W-1:0];
    end
  endfunction

  function automatic logic signed [amvi_pkg::VSUM_W-1:0] sat_add_vsum(
    input logic signed [amvi_pkg::VSUM_W-1:0] a,
    input logic signed [amvi_pkg::SUM_W-1:0]  b
  );
    logic signed [amvi_pkg::VSUM_W:0] s;
    s = (amvi_pkg::VSUM_W+1)'(a) + (amvi_pkg::VSUM_W+1)'(b);
    if (s[amvi_pkg::VSUM_W] != s[amvi_pkg::VSUM_W-1]) begin
      sat_add_vsum = s[amvi_pkg::VSUM_W] ? {1'b1, {(amvi_pkg::VSUM_W-1){1'b0}}}
                                         : {1'b0, {(amvi_pkg::VSUM_W-1){1'b1}}};
    end else begin
      sat_add_vsum = s[amvi_pkg::VSUM_W-1:0];
    end
  endfunction

  logic [2:0]                                state_r, state_nxt;
  logic [1:0]                                axis_r;
  logic                                      phase_r;
  logic                                      full_r;
  logic                                      neg_r;
  logic                                      out_valid_r;
  logic                                      kind_r;
  logic                                      no_samples_r;
  logic [amvi_pkg::GAIN_W-1:0]               gain_r;
  logic [amvi_pkg::COUNT_BITS-1:0]           count_r;
  logic signed [amvi_pkg::SUM_W-1:0]         acc_sum_r [3];
  logic signed [amvi_pkg::SUM_W-1:0]         vel_r     [3];
  logic signed [amvi_pkg::VSUM_W-1:0]        vel_sum_r [3];
  logic signed [amvi_pkg::SAMPLE_BITS-1:0]   raw_r     [3];
  logic signed [amvi_pkg::PROD_W-1:0]        prod_r;
  logic signed [amvi_pkg::ACC_W-1:0]         acc_out_r [3];
  logic signed [amvi_pkg::MVEL_W-1:0]        mvel_out_r[3];

  logic signed [amvi_pkg::PROD_W-1:0]        prod_bias;
  logic signed [amvi_pkg::PROD_W-1:0]        prod_shift;
  logic signed [amvi_pkg::ACC_W-1:0]         scaled;
  logic signed [amvi_pkg::SUM_W-1:0]         vel_new;
  logic signed [amvi_pkg::VSUM_W-1:0]        div_src;
  logic [amvi_pkg::VSUM_W-1:0]               div_mag;
  logic                                      div_start;
  logic                                      div_done;
  logic [amvi_pkg::VSUM_W-1:0]               div_q;
  logic [amvi_pkg::VSUM_W-1:0]               q_signed;
  logic                                      accept;

  assign accept = start && (state_r == ST_IDLE);

  // truncation toward zero of product >> 8
  assign prod_bias  = prod_r[amvi_pkg::PROD_W-1]
                      ? amvi_pkg::PROD_W'((1 << amvi_pkg::SHIFT) - 1) : '0;
  assign prod_shift = (prod_r + prod_bias) >>> amvi_pkg::SHIFT;
  assign scaled     = amvi_pkg::ACC_W'(prod_shift);
  assign vel_new    = sat_add_sum(vel_r[axis_r], scaled);

  assign div_src   = phase_r ? vel_sum_r[axis_r] : amvi_pkg::VSUM_W'(acc_sum_r[axis_r]);
  assign div_mag   = div_src[amvi_pkg::VSUM_W-1] ? ('0 - div_src) : div_src;
  assign div_start = (state_r == ST_DLOAD);
  assign q_signed  = neg_r ? ('0 - div_q) : div_q;

  amvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_kind == amvi_pkg::KIND_SAMPLE) begin
            state_nxt = ST_MUL;
          end else if (count_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DLOAD;
          end
        end
      end
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (!full_r) begin
          state_nxt = ST_VSUM;
        end else if (axis_r == AXIS_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_VSUM:  state_nxt = (axis_r == AXIS_LAST) ? ST_DONE : ST_MUL;
      ST_DLOAD: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_nxt = (axis_r == AXIS_LAST && phase_r) ? ST_DONE : ST_DLOAD;
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= amvi_pkg::GAIN_RESET;
      count_r     <= '0;
      axis_r      <= '0;
      phase_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_sum_r[i] <= '0;
        vel_r[i]     <= '0;
        vel_sum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      case (state_r)
        ST_IDLE: begin
          axis_r  <= '0;
          phase_r <= 1'b0;
        end
        ST_ACC: begin
          if (!full_r) begin
            acc_sum_r[axis_r] <= sat_add_sum(acc_sum_r[axis_r], scaled);
            vel_r[axis_r]     <= vel_new;
          end else begin
            axis_r <= axis_r + 1'b1;
          end
        end
        ST_VSUM: begin
          vel_sum_r[axis_r] <= sat_add_vsum(vel_sum_r[axis_r], vel_r[axis_r]);
          axis_r            <= axis_r + 1'b1;
          if (axis_r == AXIS_LAST) begin
            count_r <= count_r + 1'b1;
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (axis_r == AXIS_LAST) begin
              axis_r  <= '0;
              phase_r <= 1'b1;
            end else begin
              axis_r <= axis_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= in_kind;
      raw_r[0]     <= amvi_pkg::SAMPLE_BITS'(in_raw_x);
      raw_r[1]     <= amvi_pkg::SAMPLE_BITS'(in_raw_y);
      raw_r[2]     <= amvi_pkg::SAMPLE_BITS'(in_raw_z);
      full_r       <= (count_r == amvi_pkg::COUNT_MAX);
      no_samples_r <= (in_kind == amvi_pkg::KIND_REPORT) && (count_r == '0);
      for (int i = 0; i < 3; i++) begin
        acc_out_r[i]  <= '0;
        mvel_out_r[i] <= '0;
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= amvi_pkg::PROD_W'(raw_r[axis_r])
              * amvi_pkg::PROD_W'(signed'({1'b0, gain_r}));
    end
    if (state_r == ST_ACC) begin
      acc_out_r[axis_r] <= scaled;
    end
    if (state_r == ST_DLOAD) begin
      neg_r <= div_src[amvi_pkg::VSUM_W-1];
    end
    if (state_r == ST_DWAIT && div_done) begin
      if (phase_r) begin
        mvel_out_r[axis_r] <= q_signed[amvi_pkg::MVEL_W-1:0];
      end else begin
        acc_out_r[axis_r] <= q_signed[amvi_pkg::ACC_W-1:0];
      end
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_accel_x_out  = acc_out_r[0];
  assign out_accel_y_out  = acc_out_r[1];
  assign out_accel_z_out  = acc_out_r[2];
  assign out_mean_vel_x   = mvel_out_r[0];
  assign out_mean_vel_y   = mvel_out_r[1];
  assign out_mean_vel_z   = mvel_out_r[2];
  assign out_sample_total = amvi_pkg::TOTAL_W'(count_r);
  assign out_no_samples   = no_samples_r;
  assign out_count_full   = full_r && (kind_r == amvi_pkg::KIND_SAMPLE);

endmodule

[design/amvi_checker.sv]
// port-level checks for the integrator top level
// bound to accel_mean_velocity_integrator_core; uses amvi_pkg

module amvi_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic                                  out_result_kind,
  input logic signed [amvi_pkg::ACC_W-1:0]     out_accel_x_out,
  input logic signed [amvi_pkg::MVEL_W-1:0]    out_mean_vel_x,
  input logic signed [amvi_pkg::MVEL_W-1:0]    out_mean_vel_y,
  input logic signed [amvi_pkg::MVEL_W-1:0]    out_mean_vel_z,
  input logic [amvi_pkg::TOTAL_W-1:0]          out_sample_total,
  input logic                                  out_no_samples,
  input logic                                  out_count_full
);

  // accepted item makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted item");

  // result shows only when idle and for a single cycle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result strobe while busy or held");

  // sample results carry no means and no empty flag
  a_sample_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == amvi_pkg::KIND_SAMPLE) |->
      !out_no_samples && out_mean_vel_x == '0 && out_mean_vel_y == '0
      && out_mean_vel_z == '0)
    else $error("sample result has report fields set");

  // empty report is a report with zero sample total, zero x acceleration and no full flag
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_samples |->
      out_result_kind == amvi_pkg::KIND_REPORT && out_sample_total == '0
      && out_accel_x_out == '0 && !out_count_full)
    else $error("empty report carries data");

endmodule

bind accel_mean_velocity_integrator_core amvi_checker u_amvi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_kind  (out_result_kind),
  .out_accel_x_out  (out_accel_x_out),
  .out_mean_vel_x   (out_mean_vel_x),
  .out_mean_vel_y   (out_mean_vel_y),
  .out_mean_vel_z   (out_mean_vel_z),
  .out_sample_total (out_sample_total),
  .out_no_samples   (out_no_samples),
  .out_count_full   (out_count_full)
);
